@@ sv/crcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-8 request frame receiver package
// Shared types, result codes and the byte-wide CRC-8 update used by the
// frame parser and the top level.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned RemW  = LenW + 1;

  localparam logic [ByteW-1:0] CrcPoly = 8'h07;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;
  localparam logic [LenW-1:0]  MaxPayloadReset = 16'd256;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_t;

  // Result kind codes
  typedef enum logic [2:0] {
    K_HEADER   = 3'd0,
    K_DATA     = 3'd1,
    K_GOOD     = 3'd2,
    K_CRCERR   = 3'd3,
    K_OVERSIZE = 3'd4,
    K_ABORT    = 3'd5
  } kind_t;

  // One received item: a byte or a receive timeout
  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             rx_timeout;
  } item_t;

  // One result transaction
  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  length;
    logic [ByteW-1:0] data_byte;
  } result_t;

  // CRC-8, MSB first, one byte per call; eight shallow shift/xor steps.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/crcfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item for the parser; refills in the same cycle that
// the parser takes the held item.
// ----------------------------------------------------------------------------
module crcfr_in_stage
  import crcfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] rx_byte,
  input  logic             rx_timeout,
  input  logic             take,
  output logic             item_valid,
  output item_t            item
);

  // Ready whenever the register is empty or is being emptied this cycle
  assign in_ready = !item_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload capture on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.rx_byte    <= rx_byte;
      item.rx_timeout <= rx_timeout;
    end
  end

endmodule

@@ sv/crcfr_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Phase machine with running CRC-8 and length bookkeeping; consumes one
// item per step and produces at most one result for it.
// ----------------------------------------------------------------------------
module crcfr_parser
  import crcfr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  item_t           item,
  input  logic [LenW-1:0] max_payload,
  output logic            res_valid,
  output result_t         res
);

  phase_t           phase, phase_next;
  logic [ByteW-1:0] held_command, held_command_next;
  logic [ByteW-1:0] low_length_byte, low_length_byte_next;
  logic [LenW-1:0]  frame_length, frame_length_next;
  logic [RemW-1:0]  bytes_remaining, bytes_remaining_next;
  logic [ByteW-1:0] running_crc, running_crc_next;

  logic [ByteW-1:0] crc_step;
  logic [LenW-1:0]  rx_length;
  logic [RemW-1:0]  rem_dec;
  logic             oversize;

  // Shared datapath terms
  assign crc_step  = crc8_update(running_crc, item.rx_byte);
  assign rx_length = {item.rx_byte, low_length_byte};
  assign rem_dec   = bytes_remaining - RemW'(1);
  assign oversize  = rx_length > max_payload;

  // Next state and frame bookkeeping
  always_comb begin
    phase_next           = phase;
    held_command_next    = held_command;
    low_length_byte_next = low_length_byte;
    frame_length_next    = frame_length;
    bytes_remaining_next = bytes_remaining;
    running_crc_next     = running_crc;
    unique case (phase)
      PH_LEN_LO: begin
        if (item.rx_timeout) begin
          phase_next = PH_IDLE;
        end else begin
          low_length_byte_next = item.rx_byte;
          running_crc_next     = crc_step;
          phase_next           = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        if (item.rx_timeout) begin
          phase_next = PH_IDLE;
        end else begin
          frame_length_next = rx_length;
          if (oversize) begin
            bytes_remaining_next = {1'b0, rx_length} + RemW'(1);
            phase_next           = PH_DRAIN;
          end else begin
            running_crc_next     = crc_step;
            bytes_remaining_next = {1'b0, rx_length};
            phase_next           = (rx_length != '0) ? PH_PAYLOAD : PH_CRC;
          end
        end
      end
      PH_PAYLOAD: begin
        if (item.rx_timeout) begin
          phase_next = PH_IDLE;
        end else begin
          running_crc_next     = crc_step;
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        phase_next = PH_IDLE;
      end
      PH_DRAIN: begin
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (!item.rx_timeout) begin
          held_command_next    = item.rx_byte;
          low_length_byte_next = '0;
          frame_length_next    = '0;
          bytes_remaining_next = '0;
          running_crc_next     = crc8_update(CrcInit, item.rx_byte);
          phase_next           = PH_LEN_LO;
        end
      end
    endcase
  end

  // Result for the item in hand
  always_comb begin
    res_valid     = 1'b0;
    res.kind      = K_HEADER;
    res.command   = held_command_next;
    res.length    = frame_length_next;
    res.data_byte = '0;
    unique case (phase)
      PH_LEN_LO: begin
        if (item.rx_timeout) begin
          res_valid = 1'b1;
          res.kind  = K_ABORT;
        end
      end
      PH_LEN_HI: begin
        if (item.rx_timeout) begin
          res_valid = 1'b1;
          res.kind  = K_ABORT;
        end else if (!oversize) begin
          res_valid = 1'b1;
          res.kind  = K_HEADER;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        if (item.rx_timeout) begin
          res.kind = K_ABORT;
        end else begin
          res.kind      = K_DATA;
          res.data_byte = item.rx_byte;
        end
      end
      PH_CRC: begin
        res_valid = 1'b1;
        if (item.rx_timeout) begin
          res.kind = K_ABORT;
        end else if (item.rx_byte == running_crc) begin
          res.kind = K_GOOD;
        end else begin
          res.kind = K_CRCERR;
        end
      end
      PH_DRAIN: begin
        if (rem_dec == '0) begin
          res_valid = 1'b1;
          res.kind  = K_OVERSIZE;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Frame context registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_command    <= '0;
      low_length_byte <= '0;
      frame_length    <= '0;
      bytes_remaining <= '0;
      running_crc     <= '0;
    end else if (step) begin
      held_command    <= held_command_next;
      low_length_byte <= low_length_byte_next;
      frame_length    <= frame_length_next;
      bytes_remaining <= bytes_remaining_next;
      running_crc     <= running_crc_next;
    end
  end

endmodule

@@ sv/crcfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the consumer takes it; can be
// reloaded in the same cycle that it is emptied.
// ----------------------------------------------------------------------------
module crcfr_out_stage
  import crcfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    free,
  output result_t held
);

  // Space for a new result when empty or being taken now
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

@@ sv/crc8_request_frame_receiver.sv @@
// Path: an accepted item passes through the input register, then the parser
// and the result register. Throughput: one item per cycle while the result
// register has room, set by the single parser step between the two registers.
// Reset: synchronous; clears the phase to idle, the frame context and both
// valid flags, and sets max_payload to 256.
// ----------------------------------------------------------------------------
// CRC-8 request frame receiver
// Parses command, little-endian length, payload and CRC-8 byte frames and
// reports header, payload bytes and a final verdict.
// ----------------------------------------------------------------------------
module crc8_request_frame_receiver
  import crcfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LenW-1:0]  cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] rx_byte,
  input  logic             rx_timeout,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       kind,
  output logic [ByteW-1:0] command,
  output logic [LenW-1:0]  length,
  output logic [ByteW-1:0] data_byte
);

  logic [LenW-1:0] max_payload;
  logic            item_valid;
  item_t           item;
  logic            step;
  logic            res_valid;
  result_t         res;
  logic            out_free;
  result_t         held;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MaxPayloadReset;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  // The parser steps whenever an item is held and the result register has room
  assign step = item_valid && out_free;

  crcfr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .rx_timeout (rx_timeout),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  crcfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  crcfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .held      (held)
  );

  // Result fields
  assign kind      = held.kind;
  assign command   = held.command;
  assign length    = held.length;
  assign data_byte = held.data_byte;

endmodule
